@@ sv/x86e_pkg.sv @@
// Package for the x86-64 instruction encoder: mode codes, opcode constants
// and the instruction buffer type. No dependencies.
`default_nettype none
package x86e_pkg;
	localparam int MaxBytes = 10;

	typedef enum logic [5:0] {
		M_MOV_RR = 6'd0, M_MOV_I64 = 6'd1, M_MOV_I32 = 6'd2, M_LOAD = 6'd3,
		M_STORE = 6'd4, M_LEA = 6'd5, M_ADD_RR = 6'd6, M_ADD_I = 6'd7,
		M_SUB_RR = 6'd8, M_SUB_I = 6'd9, M_IMUL = 6'd10, M_IDIV = 6'd11,
		M_NEG = 6'd12, M_AND = 6'd13, M_OR = 6'd14, M_XOR = 6'd15,
		M_NOT = 6'd16, M_SHL = 6'd17, M_SHR = 6'd18, M_CMP_RR = 6'd19,
		M_CMP_I = 6'd20, M_TEST = 6'd21, M_SETCC = 6'd22, M_PUSH = 6'd23,
		M_POP = 6'd24, M_JMP = 6'd25, M_JCC = 6'd26, M_CALL = 6'd27,
		M_CALL_R = 6'd28, M_RET = 6'd29, M_MOVSD = 6'd30, M_ADDSD = 6'd31,
		M_SUBSD = 6'd32, M_MULSD = 6'd33, M_DIVSD = 6'd34
	} mode_t;

	localparam logic [7:0] RexW = 8'h48;
	localparam logic [7:0] RexR = 8'h44;
	localparam logic [7:0] RexB = 8'h41;
	localparam logic [7:0] RexPlain = 8'h40;
	localparam logic [7:0] OpMovSt = 8'h89;
	localparam logic [7:0] OpMovLd = 8'h8B;
	localparam logic [7:0] OpLea = 8'h8D;
	localparam logic [7:0] OpGrpI8 = 8'h83;
	localparam logic [7:0] OpGrpI32 = 8'h81;
	localparam logic [7:0] OpMovI32 = 8'hC7;
	localparam logic [7:0] OpMovI64 = 8'hB8;
	localparam logic [7:0] PfxF2 = 8'hF2;
	localparam logic [7:0] SibRsp = 8'h24;

	typedef logic [MaxBytes-1:0][7:0] bytes_t;
	typedef logic [3:0] cnt_t;
endpackage
`default_nettype wire

@@ sv/x86_64_instruction_encoder.sv @@
// x86-64 instruction encoder top level.
// Depends on x86e_pkg.
//
// Each request is encoded combinationally and registered into a buffer of up
// to ten bytes, which then drains one byte per cycle on the output while
// out_stall is low; a request that encodes to zero bytes gives no output. While
// busy, a new request is taken only in the cycle the last byte leaves.
`default_nettype none
module x86_64_instruction_encoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [5:0]  mode,
	input  wire logic [3:0]  first_reg,
	input  wire logic [3:0]  second_reg,
	input  wire logic [3:0]  cond_code,
	input  wire logic signed [63:0] imm_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       code_byte,
	output logic             last_byte,
	output logic [31:0]      byte_offset
);
	x86e_pkg::bytes_t buf_q, enc;
	x86e_pkg::cnt_t n_q, idx_q, n;
	logic [31:0] pos_q;
	logic busy_q;

	function automatic logic [7:0] modrm(input logic [1:0] md, input logic [2:0] rg,
		input logic [2:0] rm);
		modrm = {md, rg, rm};
	endfunction
	function automatic logic [7:0] rexw(input logic rg, input logic rm);
		rexw = x86e_pkg::RexW | (rg ? x86e_pkg::RexR : 8'h00) | (rm ? x86e_pkg::RexB : 8'h00);
	endfunction

	logic [31:0] lo;
	logic d0, d8, i8, sib;
	logic [2:0] bl;
	logic [7:0] op, sop, mb;
	always_comb begin
		lo = imm_value[31:0];
		bl = second_reg[2:0];
		d8 = (lo[31:7] == 25'h0) || (lo[31:7] == 25'h1FFFFFF);
		i8 = d8;
		d0 = (lo == 32'h0) && (bl != 3'd5);
		sib = (bl == 3'd4);
		enc = '0;
		n = '0;
		op = 8'h00;
		sop = 8'h00;
		mb = 8'h00;
		unique case (mode)
			x86e_pkg::M_MOV_RR, x86e_pkg::M_ADD_RR, x86e_pkg::M_SUB_RR, x86e_pkg::M_AND,
			x86e_pkg::M_OR, x86e_pkg::M_XOR, x86e_pkg::M_CMP_RR, x86e_pkg::M_TEST: begin
				unique case (mode)
					x86e_pkg::M_MOV_RR: op = x86e_pkg::OpMovSt;
					x86e_pkg::M_ADD_RR: op = 8'h01;
					x86e_pkg::M_SUB_RR: op = 8'h29;
					x86e_pkg::M_AND: op = 8'h21;
					x86e_pkg::M_OR: op = 8'h09;
					x86e_pkg::M_XOR: op = 8'h31;
					x86e_pkg::M_CMP_RR: op = 8'h39;
					default: op = 8'h85;
				endcase
				enc[0] = rexw(second_reg[3], first_reg[3]);
				enc[1] = op;
				enc[2] = modrm(2'd3, second_reg[2:0], first_reg[2:0]);
				n = (mode == x86e_pkg::M_MOV_RR && first_reg == second_reg) ? 4'd0 : 4'd3;
			end
			x86e_pkg::M_MOV_I64: begin
				enc[0] = rexw(1'b0, first_reg[3]);
				enc[1] = x86e_pkg::OpMovI64 + {5'd0, first_reg[2:0]};
				for (int k = 0; k < 8; k++) enc[2+k] = imm_value[8*k +: 8];
				n = 4'd10;
			end
			x86e_pkg::M_MOV_I32: begin
				enc[0] = rexw(1'b0, first_reg[3]);
				enc[1] = x86e_pkg::OpMovI32;
				enc[2] = modrm(2'd3, 3'd0, first_reg[2:0]);
				for (int k = 0; k < 4; k++) enc[3+k] = lo[8*k +: 8];
				n = 4'd7;
			end
			x86e_pkg::M_LOAD, x86e_pkg::M_STORE, x86e_pkg::M_LEA: begin
				enc[0] = rexw(first_reg[3], second_reg[3]);
				enc[1] = (mode == x86e_pkg::M_LOAD) ? x86e_pkg::OpMovLd :
					(mode == x86e_pkg::M_STORE) ? x86e_pkg::OpMovSt : x86e_pkg::OpLea;
				enc[2] = modrm(d0 ? 2'd0 : (d8 ? 2'd1 : 2'd2), first_reg[2:0], bl);
				if (sib) enc[3] = x86e_pkg::SibRsp;
				for (int k = 0; k < 4; k++) enc[(sib ? 4 : 3)+k] = lo[8*k +: 8];
				n = 4'd3 + {3'd0, sib} + (d0 ? 4'd0 : (d8 ? 4'd1 : 4'd4));
			end
			x86e_pkg::M_ADD_I, x86e_pkg::M_SUB_I, x86e_pkg::M_CMP_I: begin
				enc[0] = rexw(1'b0, first_reg[3]);
				enc[1] = i8 ? x86e_pkg::OpGrpI8 : x86e_pkg::OpGrpI32;
				enc[2] = modrm(2'd3, (mode == x86e_pkg::M_ADD_I) ? 3'd0 :
					(mode == x86e_pkg::M_SUB_I) ? 3'd5 : 3'd7, first_reg[2:0]);
				for (int k = 0; k < 4; k++) enc[3+k] = lo[8*k +: 8];
				n = i8 ? 4'd4 : 4'd7;
			end
			x86e_pkg::M_IMUL: begin
				enc[0] = rexw(first_reg[3], second_reg[3]);
				enc[1] = 8'h0F;
				enc[2] = 8'hAF;
				enc[3] = modrm(2'd3, first_reg[2:0], second_reg[2:0]);
				n = 4'd4;
			end
			x86e_pkg::M_IDIV, x86e_pkg::M_NEG, x86e_pkg::M_NOT, x86e_pkg::M_SHL,
			x86e_pkg::M_SHR: begin
				enc[0] = rexw(1'b0, first_reg[3]);
				enc[1] = (mode == x86e_pkg::M_SHL || mode == x86e_pkg::M_SHR) ? 8'hC1 : 8'hF7;
				enc[2] = modrm(2'd3, (mode == x86e_pkg::M_IDIV) ? 3'd7 :
					(mode == x86e_pkg::M_NEG) ? 3'd3 : (mode == x86e_pkg::M_NOT) ? 3'd2 :
					(mode == x86e_pkg::M_SHL) ? 3'd4 : 3'd5, first_reg[2:0]);
				enc[3] = lo[7:0];
				n = (mode == x86e_pkg::M_SHL || mode == x86e_pkg::M_SHR) ? 4'd4 : 4'd3;
			end
			x86e_pkg::M_SETCC: begin
				// spl..dil need a bare REX so they are not read as ah..bh.
				mb = first_reg[3] ? x86e_pkg::RexB : x86e_pkg::RexPlain;
				if (first_reg[3] || first_reg[2]) begin
					enc[0] = mb;
					enc[1] = 8'h0F;
					enc[2] = 8'h90 + {4'd0, cond_code};
					enc[3] = modrm(2'd3, 3'd0, first_reg[2:0]);
					n = 4'd4;
				end else begin
					enc[0] = 8'h0F;
					enc[1] = 8'h90 + {4'd0, cond_code};
					enc[2] = modrm(2'd3, 3'd0, first_reg[2:0]);
					n = 4'd3;
				end
			end
			x86e_pkg::M_PUSH, x86e_pkg::M_POP, x86e_pkg::M_CALL_R: begin
				unique case (mode)
					x86e_pkg::M_PUSH: begin
						op = 8'h50 + {5'd0, first_reg[2:0]};
						sop = 8'h00;
					end
					x86e_pkg::M_POP: begin
						op = 8'h58 + {5'd0, first_reg[2:0]};
						sop = 8'h00;
					end
					default: begin
						op = 8'hFF;
						sop = modrm(2'd3, 3'd2, first_reg[2:0]);
					end
				endcase
				if (first_reg[3]) begin
					enc[0] = x86e_pkg::RexB;
					enc[1] = op;
					enc[2] = sop;
				end else begin
					enc[0] = op;
					enc[1] = sop;
				end
				n = {3'd0, first_reg[3]} + ((mode == x86e_pkg::M_CALL_R) ? 4'd2 : 4'd1);
			end
			x86e_pkg::M_JMP, x86e_pkg::M_CALL: begin
				enc[0] = (mode == x86e_pkg::M_JMP) ? 8'hE9 : 8'hE8;
				for (int k = 0; k < 4; k++) enc[1+k] = lo[8*k +: 8];
				n = 4'd5;
			end
			x86e_pkg::M_JCC: begin
				enc[0] = 8'h0F;
				enc[1] = 8'h80 + {4'd0, cond_code};
				for (int k = 0; k < 4; k++) enc[2+k] = lo[8*k +: 8];
				n = 4'd6;
			end
			x86e_pkg::M_RET: begin
				enc[0] = 8'hC3;
				n = 4'd1;
			end
			x86e_pkg::M_MOVSD, x86e_pkg::M_ADDSD, x86e_pkg::M_SUBSD, x86e_pkg::M_MULSD,
			x86e_pkg::M_DIVSD: begin
				unique case (mode)
					x86e_pkg::M_MOVSD: sop = 8'h10;
					x86e_pkg::M_ADDSD: sop = 8'h58;
					x86e_pkg::M_SUBSD: sop = 8'h5C;
					x86e_pkg::M_MULSD: sop = 8'h59;
					default: sop = 8'h5E;
				endcase
				mb = x86e_pkg::RexPlain | (first_reg[3] ? x86e_pkg::RexR : 8'h00) |
					(second_reg[3] ? x86e_pkg::RexB : 8'h00);
				enc[0] = x86e_pkg::PfxF2;
				if (first_reg[3] || second_reg[3]) begin
					enc[1] = mb;
					enc[2] = 8'h0F;
					enc[3] = sop;
					enc[4] = modrm(2'd3, first_reg[2:0], second_reg[2:0]);
					n = 4'd5;
				end else begin
					enc[1] = 8'h0F;
					enc[2] = sop;
					enc[3] = modrm(2'd3, first_reg[2:0], second_reg[2:0]);
					n = 4'd4;
				end
			end
			default: n = '0;
		endcase
	end

	logic draining, take;
	assign draining = busy_q && !out_stall && (idx_q == n_q - 4'd1);
	assign in_stall = busy_q && !draining;
	assign take = in_valid && !in_stall;
	assign out_valid = busy_q;
	assign code_byte = buf_q[idx_q];
	assign last_byte = (idx_q == n_q - 4'd1);
	assign byte_offset = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			n_q <= '0;
			pos_q <= '0;
		end else begin
			if (busy_q && !out_stall) begin
				pos_q <= pos_q + 32'd1;
				idx_q <= idx_q + 4'd1;
			end
			if (draining) busy_q <= 1'b0;
			if (take) begin
				busy_q <= (n != 4'd0);
				idx_q <= '0;
				n_q <= n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) buf_q <= enc;
	end
endmodule
`default_nettype wire
